>>> rtl/core/bbk_pkg.sv
// ----------------------------------------------------------------------------
// bbk_pkg
// Shared types, Q30 constants and constant-time helpers for the blackbody
// kelvin-to-RGB pipeline.
// ----------------------------------------------------------------------------
`default_nettype none

package bbk_pkg;

    // Output format default
    localparam int OUT_FRAC_BITS_DEF = 12;

    // Pipeline geometry
    localparam int LOG_STEPS = 30;   // fraction bits of log2, one cell each
    localparam int EXP_TERMS = 21;   // Taylor terms, one cell each
    localparam int EXP_LAT   = 3;    // register stages in one exp cell

    // Q30 constants
    localparam logic [30:0] ONE_Q30     = 31'h4000_0000;
    localparam logic [29:0] LN2_Q30     = 30'd744261118;
    localparam logic [28:0] GRN_LO_GAIN = 29'd418846906;
    localparam logic [32:0] GRN_LO_BIAS = 33'd678434584;
    localparam logic [29:0] BLU_GAIN    = 30'd583263849;
    localparam logic [32:0] BLU_BIAS    = 33'd1284468048;
    localparam logic [30:0] RED_HI_GAIN = 31'd1388279659;
    localparam logic [27:0] RED_HI_EXP  = 28'd143027521;
    localparam logic [30:0] GRN_HI_GAIN = 31'd1213211074;
    localparam logic [26:0] GRN_HI_EXP  = 27'd81083452;

    // Kelvin limits and branch points
    localparam logic [15:0] K_MIN     = 16'd1000;
    localparam logic [15:0] K_MAX     = 16'd40000;
    localparam logic [15:0] K_LO_TOP  = 16'd6600;
    localparam logic [15:0] K_BLU_OFF = 16'd1900;
    localparam logic [15:0] K_HI_OFS  = 16'd6000;
    localparam logic [15:0] K_BLU_OFS = 16'd1000;

    // Mantissa and partial log2 handed into the log chain
    typedef struct packed {
        logic [30:0] m;
        logic [33:0] res;
    } norm_t;

    // Side data riding along the log chain
    typedef struct packed {
        logic lo;
        logic bz;
    } lsb_t;

    // Side data riding along the exp chain
    typedef struct packed {
        logic        lo;
        logic        bz;
        logic [32:0] g_lo;
        logic [32:0] b_lo;
        logic [1:0]  wr;
        logic [1:0]  wg;
    } xsb_t;

    // Normalize n to [1,2) in Q30; exponent goes to the integer part of res
    function automatic norm_t norm_q30(input logic [15:0] n);
        norm_t       o;
        logic [3:0]  e;
        e = '0;
        for (int i = 0; i < 16; i++)
        begin
            if (n[i])
                e = 4'(i);
        end
        o.m   = 31'({15'd0, n} << (5'd30 - {1'b0, e}));
        o.res = {e, 30'd0};
        return o;
    endfunction

    // Elaboration-time log2 in Q30, same rounds as the hardware chain
    function automatic logic [33:0] log2_q30_const(input logic [15:0] n);
        logic [63:0] m;
        norm_t       nm;
        logic [33:0] res;
        nm  = norm_q30(n);
        m   = 64'(nm.m);
        res = nm.res;
        for (int i = 29; i >= 0; i--)
        begin
            m = (m * m) >> 30;
            if (m >= 64'h8000_0000)
            begin
                m      = m >> 1;
                res[i] = 1'b1;
            end
        end
        return res;
    endfunction

endpackage

`default_nettype wire

>>> rtl/core/blackbody_kelvin_to_rgb_top.sv
// Converts a color temperature in kelvin to red, green and blue levels in
// unsigned Q1.OUT_FRAC_BITS along the usual blackbody fit. The block is a
// fully pipelined row of cells and takes one beat every cycle while the output
// is not stalled; each beat passes 30 log2 squaring cells, 21 Taylor cells of
// three stages each, and seven stages of input, setup, scaling and output
// register. A stalled output holds the whole row, so the input is ready
// whenever the output register is empty or being taken.
// ----------------------------------------------------------------------------
// blackbody_kelvin_to_rgb_top
// Kelvin to RGB: clamp, two log2 chains, fit coefficients, two exp chains,
// saturation and rounding.
// ----------------------------------------------------------------------------
`default_nettype none

module blackbody_kelvin_to_rgb_top #(
    parameter  int OUT_FRAC_BITS = bbk_pkg::OUT_FRAC_BITS_DEF,
    localparam int LEVEL_W       = OUT_FRAC_BITS + 1,
    localparam int TDATA_W       = ((3 * LEVEL_W + 7) / 8) * 8
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               s_tvalid,
    output logic               s_tready,
    input  logic [15:0]        s_tdata,   // temperature_kelvin
    output logic               m_tvalid,
    input  logic               m_tready,
    output logic [TDATA_W-1:0] m_tdata    // red_level, green_level, blue_level
);
    import bbk_pkg::*;

    localparam int PIPE_DEPTH = LOG_STEPS + EXP_TERMS * EXP_LAT + 6;
    localparam int XSB_DEPTH  = EXP_TERMS * EXP_LAT;
    localparam logic [33:0] LOG2_100 = log2_q30_const(16'd100);
    localparam logic [30:0] RND      = 31'(1) << (29 - OUT_FRAC_BITS);

    logic adv;
    logic [PIPE_DEPTH-1:0] vld_reg;
    logic out_valid_reg;

    // whole row moves unless a finished beat is waiting
    assign adv      = !out_valid_reg || m_tready;
    assign s_tready = adv;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            vld_reg       <= {vld_reg[PIPE_DEPTH-2:0], s_tvalid};
            out_valid_reg <= vld_reg[PIPE_DEPTH-1];
        end
    end

    // ---------------- input stage: clamp, branch, normalize ----------------
    logic [15:0] k;
    logic [15:0] n1;
    logic [15:0] n2;
    norm_t       nm1;
    norm_t       nm2;
    lsb_t        sb0;

    always_comb
    begin
        if (s_tdata < K_MIN)
            k = K_MIN;
        else if (s_tdata > K_MAX)
            k = K_MAX;
        else
            k = s_tdata;
        sb0.lo = (k <= K_LO_TOP);
        sb0.bz = (k <= K_BLU_OFF);
        n1     = sb0.lo ? k : (k - K_HI_OFS);
        n2     = k - K_BLU_OFS;
        nm1    = norm_q30(n1);
        nm2    = norm_q30(n2);
    end

    logic [30:0] lm1 [0:LOG_STEPS];
    logic [33:0] lr1 [0:LOG_STEPS];
    logic [30:0] lm2 [0:LOG_STEPS];
    logic [33:0] lr2 [0:LOG_STEPS];
    lsb_t        lsb_reg [0:LOG_STEPS];
    logic [30:0] in_m1_reg;
    logic [33:0] in_r1_reg;
    logic [30:0] in_m2_reg;
    logic [33:0] in_r2_reg;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            in_m1_reg  <= nm1.m;
            in_r1_reg  <= nm1.res;
            in_m2_reg  <= nm2.m;
            in_r2_reg  <= nm2.res;
            lsb_reg[0] <= sb0;
            for (int i = 1; i <= LOG_STEPS; i++)
                lsb_reg[i] <= lsb_reg[i-1];
        end
    end

    assign lm1[0] = in_m1_reg;
    assign lr1[0] = in_r1_reg;
    assign lm2[0] = in_m2_reg;
    assign lr2[0] = in_r2_reg;

    // ---------------- log2 chains ----------------
    for (genvar j = 0; j < LOG_STEPS; j++)
    begin : g_log
        bbk_log_cell #(.BIT(LOG_STEPS - 1 - j)) u_log1 (
            .clk     (clk),
            .en      (adv),
            .m_in    (lm1[j]),
            .res_in  (lr1[j]),
            .m_out   (lm1[j+1]),
            .res_out (lr1[j+1])
        );
        bbk_log_cell #(.BIT(LOG_STEPS - 1 - j)) u_log2 (
            .clk     (clk),
            .en      (adv),
            .m_in    (lm2[j]),
            .res_in  (lr2[j]),
            .m_out   (lm2[j+1]),
            .res_out (lr2[j+1])
        );
    end

    // ---------------- fit setup: three stages ----------------
    logic [33:0] d1_reg;
    logic [33:0] d2_reg;
    lsb_t        sb1_reg;
    logic [33:0] ln1_reg;
    logic [33:0] ln2_reg;
    logic [31:0] qr_reg;
    logic [31:0] qg_reg;
    lsb_t        sb2_reg;
    logic [29:0] zr_reg;
    logic [29:0] zg_reg;
    xsb_t        xsb_reg [0:XSB_DEPTH];

    logic [33:0] d1_next;
    logic [33:0] d2_next;
    logic [63:0] ln1_p;
    logic [63:0] ln2_p;
    logic [61:0] qr_p;
    logic [61:0] qg_p;
    logic [62:0] pg_p;
    logic [63:0] pb_p;
    logic [30:0] fr_c;
    logic [30:0] fg_c;
    logic [60:0] zr_p;
    logic [60:0] zg_p;
    xsb_t        xsb_next;

    always_comb
    begin
        // log2(x/100), floored at zero
        d1_next = (lr1[LOG_STEPS] > LOG2_100) ? (lr1[LOG_STEPS] - LOG2_100) : '0;
        d2_next = (lr2[LOG_STEPS] > LOG2_100) ? (lr2[LOG_STEPS] - LOG2_100) : '0;
        // ln and exponent products
        ln1_p = 64'(d1_reg) * 64'(LN2_Q30);
        ln2_p = 64'(d2_reg) * 64'(LN2_Q30);
        qr_p  = 62'(d1_reg) * 62'(RED_HI_EXP);
        qg_p  = 62'(d1_reg) * 62'(GRN_HI_EXP);
        // low-branch gains and high-branch exp arguments
        pg_p  = 63'(ln1_reg) * 63'(GRN_LO_GAIN);
        pb_p  = 64'(ln2_reg) * 64'(BLU_GAIN);
        fr_c  = ONE_Q30 - {1'b0, qr_reg[29:0]};
        fg_c  = ONE_Q30 - {1'b0, qg_reg[29:0]};
        zr_p  = 61'(fr_c) * 61'(LN2_Q30);
        zg_p  = 61'(fg_c) * 61'(LN2_Q30);
        xsb_next.lo   = sb2_reg.lo;
        xsb_next.bz   = sb2_reg.bz;
        xsb_next.g_lo = pg_p[62:30];
        xsb_next.b_lo = pb_p[62:30];
        xsb_next.wr   = qr_reg[31:30];
        xsb_next.wg   = qg_reg[31:30];
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            d1_reg     <= d1_next;
            d2_reg     <= d2_next;
            sb1_reg    <= lsb_reg[LOG_STEPS];
            ln1_reg    <= ln1_p[63:30];
            ln2_reg    <= ln2_p[63:30];
            qr_reg     <= qr_p[61:30];
            qg_reg     <= qg_p[61:30];
            sb2_reg    <= sb1_reg;
            zr_reg     <= zr_p[59:30];
            zg_reg     <= zg_p[59:30];
            xsb_reg[0] <= xsb_next;
            for (int i = 1; i <= XSB_DEPTH; i++)
                xsb_reg[i] <= xsb_reg[i-1];
        end
    end

    // ---------------- exp chains for red and green ----------------
    logic [30:0] rt [0:EXP_TERMS];
    logic [31:0] rs [0:EXP_TERMS];
    logic [29:0] rz [0:EXP_TERMS];
    logic [30:0] gt [0:EXP_TERMS];
    logic [31:0] gs [0:EXP_TERMS];
    logic [29:0] gz [0:EXP_TERMS];

    assign rt[0] = ONE_Q30;
    assign rs[0] = 32'(ONE_Q30);
    assign rz[0] = zr_reg;
    assign gt[0] = ONE_Q30;
    assign gs[0] = 32'(ONE_Q30);
    assign gz[0] = zg_reg;

    for (genvar c = 0; c < EXP_TERMS; c++)
    begin : g_exp
        bbk_exp_cell #(.IDX(c + 1)) u_exp_r (
            .clk      (clk),
            .en       (adv),
            .term_in  (rt[c]),
            .sum_in   (rs[c]),
            .z_in     (rz[c]),
            .term_out (rt[c+1]),
            .sum_out  (rs[c+1]),
            .z_out    (rz[c+1])
        );
        bbk_exp_cell #(.IDX(c + 1)) u_exp_g (
            .clk      (clk),
            .en       (adv),
            .term_in  (gt[c]),
            .sum_in   (gs[c]),
            .z_in     (gz[c]),
            .term_out (gt[c+1]),
            .sum_out  (gs[c+1]),
            .z_out    (gz[c+1])
        );
    end

    // ---------------- power scaling and gains ----------------
    logic [31:0] er_reg;
    logic [31:0] eg_reg;
    xsb_t        xs_reg;
    logic [32:0] pr_reg;
    logic [32:0] ph_reg;
    xsb_t        ys_reg;
    logic [62:0] pr_p;
    logic [62:0] ph_p;

    assign pr_p = 63'(er_reg) * 63'(RED_HI_GAIN);
    assign ph_p = 63'(eg_reg) * 63'(GRN_HI_GAIN);

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            er_reg <= rs[EXP_TERMS] >> ({1'b0, xsb_reg[XSB_DEPTH].wr} + 3'd1);
            eg_reg <= gs[EXP_TERMS] >> ({1'b0, xsb_reg[XSB_DEPTH].wg} + 3'd1);
            xs_reg <= xsb_reg[XSB_DEPTH];
            pr_reg <= pr_p[62:30];
            ph_reg <= ph_p[62:30];
            ys_reg <= xs_reg;
        end
    end

    // ---------------- saturation, rounding, output register ----------------
    function automatic logic [30:0] sat_one(input logic [32:0] v);
        return (v > 33'(ONE_Q30)) ? ONE_Q30 : v[30:0];
    endfunction

    function automatic logic [30:0] affine_sat(input logic [32:0] p, input logic [32:0] bias);
        logic [32:0] d;
        d = p - bias;
        return (p <= bias) ? '0 : sat_one(d);
    endfunction

    function automatic logic [LEVEL_W-1:0] to_level(input logic [30:0] v);
        logic [30:0] s;
        s = (v + RND) >> (30 - OUT_FRAC_BITS);
        return s[LEVEL_W-1:0];
    endfunction

    logic [30:0]        r_v;
    logic [30:0]        g_v;
    logic [30:0]        b_v;
    logic [LEVEL_W-1:0] red_reg;
    logic [LEVEL_W-1:0] green_reg;
    logic [LEVEL_W-1:0] blue_reg;

    always_comb
    begin
        if (ys_reg.lo)
        begin
            r_v = ONE_Q30;
            g_v = affine_sat(ys_reg.g_lo, GRN_LO_BIAS);
            b_v = ys_reg.bz ? '0 : affine_sat(ys_reg.b_lo, BLU_BIAS);
        end
        else
        begin
            r_v = sat_one(pr_reg);
            g_v = sat_one(ph_reg);
            b_v = ONE_Q30;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            red_reg   <= to_level(r_v);
            green_reg <= to_level(g_v);
            blue_reg  <= to_level(b_v);
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = TDATA_W'({blue_reg, green_reg, red_reg});

endmodule

`default_nettype wire

>>> rtl/core/bbk_log_cell.sv
// ----------------------------------------------------------------------------
// bbk_log_cell
// One squaring round of the log2 chain: squares the mantissa and resolves
// one fraction bit of the result.
// ----------------------------------------------------------------------------
`default_nettype none

module bbk_log_cell #(
    parameter int BIT = 29
) (
    input  logic        clk,
    input  logic        en,
    input  logic [30:0] m_in,
    input  logic [33:0] res_in,
    output logic [30:0] m_out,
    output logic [33:0] res_out
);
    import bbk_pkg::*;

    logic [61:0] sq;
    logic [31:0] sq_q30;
    logic [30:0] m_next;
    logic [33:0] res_next;
    logic [30:0] m_reg;
    logic [33:0] res_reg;

    // square, renormalize when the mantissa reaches two
    always_comb
    begin
        sq       = 62'(m_in) * 62'(m_in);
        sq_q30   = sq[61:30];
        res_next = res_in;
        if (sq_q30[31])
        begin
            m_next        = sq_q30[31:1];
            res_next[BIT] = 1'b1;
        end
        else
        begin
            m_next = sq_q30[30:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            m_reg   <= m_next;
            res_reg <= res_next;
        end
    end

    assign m_out   = m_reg;
    assign res_out = res_reg;

endmodule

`default_nettype wire

>>> rtl/core/bbk_exp_cell.sv
// ----------------------------------------------------------------------------
// bbk_exp_cell
// One Taylor term of exp(z): term = (term * z >> 30) / IDX, added to the
// running sum. Three register stages: product, reciprocal, correction.
// ----------------------------------------------------------------------------
`default_nettype none

module bbk_exp_cell #(
    parameter int IDX = 1
) (
    input  logic        clk,
    input  logic        en,
    input  logic [30:0] term_in,
    input  logic [31:0] sum_in,
    input  logic [29:0] z_in,
    output logic [30:0] term_out,
    output logic [31:0] sum_out,
    output logic [29:0] z_out
);
    import bbk_pkg::*;

    // floor((2^32-1)/IDX): estimate is low by at most one
    localparam logic [31:0] REC = 32'(64'hFFFF_FFFF / IDX);
    localparam logic [29:0] DIV = 30'(IDX);

    logic [60:0] prod;
    logic [29:0] x_next;
    logic [61:0] qprod;
    logic [29:0] q_next;
    logic [34:0] qi;
    logic [29:0] rem;
    logic [29:0] t_fix;
    logic [30:0] term_next;
    logic [31:0] sum_next;

    logic [29:0] x_a_reg;
    logic [29:0] z_a_reg;
    logic [31:0] sum_a_reg;
    logic [29:0] q_b_reg;
    logic [29:0] x_b_reg;
    logic [29:0] z_b_reg;
    logic [31:0] sum_b_reg;
    logic [30:0] term_reg;
    logic [31:0] sum_reg;
    logic [29:0] z_reg;

    // stage a: term * z
    assign prod   = 61'(term_in) * 61'(z_in);
    assign x_next = prod[59:30];

    // stage b: quotient estimate
    assign qprod  = 62'(x_a_reg) * 62'(REC);
    assign q_next = qprod[61:32];

    // stage c: one correction step, then accumulate
    always_comb
    begin
        qi        = 35'(q_b_reg) * 35'(DIV);
        rem       = x_b_reg - qi[29:0];
        t_fix     = (rem >= DIV) ? (q_b_reg + 30'd1) : q_b_reg;
        term_next = {1'b0, t_fix};
        sum_next  = sum_b_reg + 32'(t_fix);
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            x_a_reg   <= x_next;
            z_a_reg   <= z_in;
            sum_a_reg <= sum_in;
            q_b_reg   <= q_next;
            x_b_reg   <= x_a_reg;
            z_b_reg   <= z_a_reg;
            sum_b_reg <= sum_a_reg;
            term_reg  <= term_next;
            sum_reg   <= sum_next;
            z_reg     <= z_b_reg;
        end
    end

    assign term_out = term_reg;
    assign sum_out  = sum_reg;
    assign z_out    = z_reg;

endmodule

`default_nettype wire

>>> tb/sv/blackbody_kelvin_to_rgb_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// blackbody_kelvin_to_rgb_checker
// Watches both stream channels, computes the expected RGB levels for every
// accepted temperature beat and compares them with the output beats in order.
// ----------------------------------------------------------------------------
`default_nettype none

module blackbody_kelvin_to_rgb_checker #(
    parameter int OUT_FRAC_BITS = 12,
    parameter int TDATA_W       = 40
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               s_tvalid,
    input  logic               s_tready,
    input  logic [15:0]        s_tdata,
    input  logic               m_tvalid,
    input  logic               m_tready,
    input  logic [TDATA_W-1:0] m_tdata,
    output int                 errors,
    output int                 pending
);

    localparam int LW = OUT_FRAC_BITS + 1;
    localparam logic [63:0] Q_ONE = 64'd1 << 30;

    typedef struct packed {
        logic [LW-1:0] blue;
        logic [LW-1:0] green;
        logic [LW-1:0] red;
    } rgb_t;

    rgb_t rgb_queue[$];

    // log2 in Q30 by repeated squaring
    function automatic logic [63:0] log2_fix(input logic [15:0] n);
        logic [63:0] m;
        logic [63:0] r;
        int e;
        if (n == 0)
            return 0;
        e = 0;
        while (e < 15 && (n >> (e + 1)) != 0)
            e++;
        m = 64'(n) << (30 - e);
        r = 64'(e) << 30;
        for (int i = 29; i >= 0; i--)
        begin
            m = (m * m) >> 30;
            if (m >= (Q_ONE << 1))
            begin
                m = m >> 1;
                r[i] = 1'b1;
            end
        end
        return r;
    endfunction

    // log2(n/100), floored at zero
    function automatic logic [63:0] log2_centi(input logic [15:0] n);
        logic [63:0] a;
        logic [63:0] b;
        a = log2_fix(n);
        b = log2_fix(16'd100);
        return (a > b) ? a - b : 64'd0;
    endfunction

    function automatic logic [63:0] exp_fix(input logic [63:0] z);
        logic [63:0] s;
        logic [63:0] t;
        s = Q_ONE;
        t = Q_ONE;
        for (int i = 1; i <= 21; i++)
        begin
            t = ((t * z) >> 30) / i;
            s += t;
        end
        return s;
    endfunction

    // (n/100)^-p in Q30
    function automatic logic [63:0] inv_power(input logic [15:0] n, input logic [63:0] p);
        logic [63:0] q;
        logic [63:0] w;
        logic [63:0] z;
        q = (p * log2_centi(n)) >> 30;
        w = q >> 30;
        z = ((Q_ONE - (q & (Q_ONE - 1))) * 64'd744261118) >> 30;
        if (w > 40)
            return 0;
        return exp_fix(z) >> (1 + w);
    endfunction

    function automatic logic [63:0] fit_line(input logic [63:0] gain, input logic [63:0] x,
                                             input logic [63:0] bias);
        logic [63:0] p;
        p = (gain * x) >> 30;
        if (p <= bias)
            return 0;
        return (p - bias > Q_ONE) ? Q_ONE : p - bias;
    endfunction

    function automatic logic [63:0] scale_sat(input logic [63:0] gain, input logic [63:0] v);
        logic [63:0] p;
        p = (gain * v) >> 30;
        return (p > Q_ONE) ? Q_ONE : p;
    endfunction

    function automatic logic [LW-1:0] to_level(input logic [63:0] v);
        return LW'((v + (64'd1 << (29 - OUT_FRAC_BITS))) >> (30 - OUT_FRAC_BITS));
    endfunction

    function automatic rgb_t kelvin_to_rgb(input logic [15:0] kin);
        logic [15:0] k;
        logic [63:0] r;
        logic [63:0] g;
        logic [63:0] b;
        rgb_t o;
        k = (kin < 16'd1000) ? 16'd1000 : (kin > 16'd40000) ? 16'd40000 : kin;
        if (k <= 16'd6600)
        begin
            r = Q_ONE;
            g = fit_line(64'd418846906, (log2_centi(k) * 64'd744261118) >> 30,
                         64'd678434584);
            if (k <= 16'd1900)
                b = 0;
            else
                b = fit_line(64'd583263849,
                             (log2_centi(k - 16'd1000) * 64'd744261118) >> 30,
                             64'd1284468048);
        end
        else
        begin
            r = scale_sat(64'd1388279659, inv_power(k - 16'd6000, 64'd143027521));
            g = scale_sat(64'd1213211074, inv_power(k - 16'd6000, 64'd81083452));
            b = Q_ONE;
        end
        o.red   = to_level(r);
        o.green = to_level(g);
        o.blue  = to_level(b);
        return o;
    endfunction

    assign pending = rgb_queue.size();

    // predict on input beats, compare on output beats
    always @(posedge clk)
    begin
        rgb_t exp_rgb;
        rgb_t got;
        if (!rst_n)
        begin
            errors = 0;
        end
        else
        begin
            if (s_tvalid && s_tready)
                rgb_queue = {rgb_queue, kelvin_to_rgb(s_tdata)};
            if (m_tvalid && m_tready)
            begin
                got = rgb_t'(m_tdata[3*LW-1:0]);
                if (rgb_queue.size() == 0)
                begin
                    $error("unexpected output beat %h", m_tdata);
                    errors++;
                end
                else
                begin
                    exp_rgb = rgb_queue.pop_front();
                    if (got.red !== exp_rgb.red)
                    begin
                        $error("red_level expected %0d actual %0d", exp_rgb.red, got.red);
                        errors++;
                    end
                    if (got.green !== exp_rgb.green)
                    begin
                        $error("green_level expected %0d actual %0d",
                               exp_rgb.green, got.green);
                        errors++;
                    end
                    if (got.blue !== exp_rgb.blue)
                    begin
                        $error("blue_level expected %0d actual %0d", exp_rgb.blue, got.blue);
                        errors++;
                    end
                end
            end
        end
    end

endmodule

`default_nettype wire

>>> tb/sv/blackbody_kelvin_to_rgb_top_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// blackbody_kelvin_to_rgb_top_tb
// Drives directed and random temperatures with random gaps and output stalls,
// including one long hold-off; the checker predicts and compares each beat.
// ----------------------------------------------------------------------------
`default_nettype none

module blackbody_kelvin_to_rgb_top_tb;

    localparam int OFB       = bbk_pkg::OUT_FRAC_BITS_DEF;
    localparam int TDW       = ((3 * (OFB + 1) + 7) / 8) * 8;
    localparam int N_RANDOM  = 1630;
    localparam int CYC_LIMIT = 400000;

    logic           clk;
    logic           rst_n;
    logic           s_tvalid;
    logic           s_tready;
    logic [15:0]    s_tdata;
    logic           m_tvalid;
    logic           m_tready;
    logic [TDW-1:0] m_tdata;
    int             errors;
    int             pending;
    int             cycles;
    bit             hold_done;

    blackbody_kelvin_to_rgb_top #(.OUT_FRAC_BITS(OFB)) DUT (
        .clk(clk), .rst_n(rst_n),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
    );

    blackbody_kelvin_to_rgb_checker #(.OUT_FRAC_BITS(OFB), .TDATA_W(TDW)) u_checker (
        .clk(clk), .rst_n(rst_n),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .errors(errors), .pending(pending)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 50)
            return 0;
        if (r < 93)
            return $urandom_range(1, 3);
        return $urandom_range(10, 60);
    endfunction

    // mostly inside the clamp window, with a share of raw 16-bit values
    function automatic logic [15:0] pick_kelvin();
        case ($urandom_range(0, 9))
            0, 1: return 16'($urandom_range(0, 65535));
            2:    return 16'($urandom_range(900, 2100));
            3:    return 16'($urandom_range(6400, 6800));
            4:    return 16'($urandom_range(39800, 40200));
            default: return 16'($urandom_range(1000, 40000));
        endcase
    endfunction

    task automatic send_kelvin(input logic [15:0] k);
        int g;
        g = gap_len();
        if (g > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (g) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= k;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
    endtask

    // receiver: random stalls, one long hold-off once traffic is flowing
    initial
    begin
        int g;
        m_tready  = 1'b0;
        hold_done = 1'b0;
        @(posedge rst_n);
        repeat (150) @(posedge clk);
        m_tready <= 1'b0;
        repeat (400) @(posedge clk);
        hold_done = 1'b1;
        forever
        begin
            m_tready <= 1'b1;
            repeat ($urandom_range(1, 12)) @(posedge clk);
            g = ($urandom_range(0, 3) == 0) ? 0 : gap_len();
            if (g > 0)
            begin
                m_tready <= 1'b0;
                repeat (g) @(posedge clk);
            end
        end
    end

    // run limit
    initial
    begin
        cycles = 0;
        forever
        begin
            @(posedge clk);
            cycles++;
            if (cycles > CYC_LIMIT)
            begin
                $display("blackbody_kelvin_to_rgb_top_tb failed");
                $finish;
            end
        end
    end

    // stimulus and verdict
    initial
    begin
        logic [15:0] directed[$];
        s_tvalid = 1'b0;
        s_tdata  = '0;
        rst_n    = 1'b0;
        directed = '{16'd0, 16'd999, 16'd1000, 16'd1001, 16'd1899, 16'd1900, 16'd1901,
                     16'd2000, 16'd6599, 16'd6600, 16'd6601, 16'd6700, 16'd12000,
                     16'd39999, 16'd40000, 16'd40001, 16'd65535, 16'h5555, 16'hAAAA,
                     16'd100, 16'd6500};
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        foreach (directed[i])
            send_kelvin(directed[i]);
        for (int i = 0; i < N_RANDOM; i++)
            send_kelvin(pick_kelvin());
        s_tvalid <= 1'b0;
        wait (hold_done && pending == 0);
        repeat (200) @(posedge clk);
        if (errors == 0 && pending == 0)
            $display("blackbody_kelvin_to_rgb_top_tb passed");
        else
            $display("blackbody_kelvin_to_rgb_top_tb failed");
        $finish;
    end

endmodule

`default_nettype wire
